### rtl/swrr_pkg.sv
// ----------------------------------------------------------------------------
// swrr_pkg: shared types and constants of the switch output arbiter
// Field layout of the stream payloads, cell flag bundle and result item.
// ----------------------------------------------------------------------------
package swrr_pkg;

  localparam int unsigned MAX_INPUTS    = 4;
  localparam int unsigned IDX_BITS      = 2;
  localparam int unsigned SLOT_BITS     = 16;
  localparam int unsigned FILL_BITS     = 16;
  localparam int unsigned SUM_BITS      = FILL_BITS + 1;
  localparam int unsigned CAP_BITS      = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd1024;

  // Input payload layout, lowest bit first.
  localparam int unsigned PRESENT_LSB   = 0;
  localparam int unsigned READY_LSB     = 4;
  localparam int unsigned READABLE_LSB  = 8;
  localparam int unsigned ROUTES_LSB    = 12;
  localparam int unsigned SIZES_LSB     = 16;
  localparam int unsigned FILL_LSB      = 80;
  localparam int unsigned WRITABLE_BIT  = 96;
  localparam int unsigned IN_DATA_BITS  = 104;
  localparam int unsigned OUT_DATA_BITS = 8;

  typedef struct packed {
    logic present;
    logic ready;
    logic readable;
    logic routes;
  } cell_flags_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] grant_index;
    logic                grant_valid;
  } res_t;

endpackage

### rtl/swrr_cell.sv
// ----------------------------------------------------------------------------
// swrr_cell: one input slot of the round-robin arbiter
// Qualifies its input and takes part in two fixed-priority chains: one for
// the slots above the last grant and one that wraps around over all slots.
// ----------------------------------------------------------------------------
module swrr_cell
  import swrr_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 16
) (
  input  cell_flags_t            flags_i,
  input  logic [SIZE_BITS-1:0]   size_i,
  input  logic [FILL_BITS-1:0]   fill_i,
  input  logic [CAP_BITS-1:0]    cap_i,
  input  logic                   writable_i,
  input  logic                   above_last_i,
  input  logic                   hi_taken_i,
  input  logic                   lo_taken_i,
  output logic                   hi_grant_o,
  output logic                   lo_grant_o,
  output logic                   hi_taken_o,
  output logic                   lo_taken_o
);

  logic [SUM_BITS-1:0] need;
  logic                fits;
  logic                req;
  logic                hi_req;

  // The sum cannot wrap on SUM_BITS, so a plain compare is exact.
  assign need   = SUM_BITS'(fill_i) + SUM_BITS'(size_i);
  assign fits   = need <= SUM_BITS'(cap_i);
  assign req    = writable_i & flags_i.present & flags_i.ready &
                  flags_i.readable & flags_i.routes & fits;
  assign hi_req = req & above_last_i;

  assign hi_grant_o = hi_req & ~hi_taken_i;
  assign lo_grant_o = req & ~lo_taken_i;
  assign hi_taken_o = hi_taken_i | hi_req;
  assign lo_taken_o = lo_taken_i | req;

endmodule

### rtl/swrr_skid.sv
// ----------------------------------------------------------------------------
// swrr_skid: output register with a skid stage
// Holds results so the input takes an item every cycle while skid is empty.
// ----------------------------------------------------------------------------
module swrr_skid
  import swrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  res_t res_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output res_t out_o,
  input  logic out_ready_i
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_i;
        out_valid_d = in_fire_i;
      end
    end else if (in_fire_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/switch_output_round_robin_arbiter_unit.sv
// ----------------------------------------------------------------------------
// switch_output_round_robin_arbiter_unit: round-robin arbiter, one output port
// Grants the first qualifying input after the last granted one, if the
// message fits into the output buffer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        request item, 104-bit tdata
//  m_axis    out        tvalid / tready        grant item, 8-bit tdata
//  cfg       in         valid / ready          output capacity, 16 bits
//
//  One item is decided per clock while s_axis_tready is high; the cell chain
//  and the pointer register form the loop that sets this rate.
//  A grant passes through the output register (via skid on a stall) to m_axis.
//  Reset sets the pointer to 0 and the capacity to 1024; no clearing pass.
//  A stall on m_axis fills a one-item skid stage before s_axis_tready drops.
// ----------------------------------------------------------------------------
module switch_output_round_robin_arbiter_unit
  import swrr_pkg::*;
#(
  parameter int unsigned NUM_INPUTS = 4,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // head_present[3:0], head_ready[7:4], input_readable[11:8],
  // routes_here[15:12], head_sizes[79:16], output_fill[95:80],
  // output_writable[96], zero fill [103:97]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // grant_valid[0], grant_index[2:1], zero fill [7:3]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [CAP_BITS-1:0]      cfg_data_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o
);

  logic [CAP_BITS-1:0] cap_q;
  logic [IDX_BITS-1:0] last_grant_q, last_grant_d;
  logic                in_fire;
  logic                writable;
  logic [FILL_BITS-1:0] fill;
  logic [NUM_INPUTS-1:0] hi_grant, lo_grant, sel;
  logic [NUM_INPUTS:0]   hi_chain, lo_chain;
  res_t                res;
  res_t                out_res;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid & s_axis_tready;
  assign writable    = s_axis_tdata[WRITABLE_BIT];
  assign fill        = s_axis_tdata[FILL_LSB +: FILL_BITS];

  assign hi_chain[0] = 1'b0;
  assign lo_chain[0] = 1'b0;

  for (genvar gi = 0; gi < NUM_INPUTS; gi++) begin : g_cell
    cell_flags_t flags;
    assign flags.present  = s_axis_tdata[PRESENT_LSB + gi];
    assign flags.ready    = s_axis_tdata[READY_LSB + gi];
    assign flags.readable = s_axis_tdata[READABLE_LSB + gi];
    assign flags.routes   = s_axis_tdata[ROUTES_LSB + gi];

    swrr_cell #(
      .SIZE_BITS(SIZE_BITS)
    ) u_cell (
      .flags_i      (flags),
      .size_i       (s_axis_tdata[SIZES_LSB + gi*SLOT_BITS +: SIZE_BITS]),
      .fill_i       (fill),
      .cap_i        (cap_q),
      .writable_i   (writable),
      .above_last_i (IDX_BITS'(gi) > last_grant_q),
      .hi_taken_i   (hi_chain[gi]),
      .lo_taken_i   (lo_chain[gi]),
      .hi_grant_o   (hi_grant[gi]),
      .lo_grant_o   (lo_grant[gi]),
      .hi_taken_o   (hi_chain[gi+1]),
      .lo_taken_o   (lo_chain[gi+1])
    );
  end

  // Slots above the pointer win; otherwise the search wraps to the lowest.
  assign sel = hi_chain[NUM_INPUTS] ? hi_grant : lo_grant;

  always_comb begin
    res.grant_valid = lo_chain[NUM_INPUTS];
    res.grant_index = '0;
    for (int i = 0; i < NUM_INPUTS; i++) begin
      if (sel[i]) begin
        res.grant_index = res.grant_index | IDX_BITS'(i);
      end
    end
  end

  assign last_grant_d = in_fire ? res.grant_index : last_grant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_grant_q <= '0;
      cap_q        <= CAP_RESET;
    end else begin
      last_grant_q <= last_grant_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  swrr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .res_i       (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_DATA_BITS - IDX_BITS - 1){1'b0}},
                         out_res.grant_index, out_res.grant_valid};

`ifndef SYNTHESIS
  a_no_grant_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == '0)
    else $error("grant index not zero without a grant");

  a_pointer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(last_grant_q) < NUM_INPUTS)
    else $error("grant pointer beyond the input count");

  a_blocked_output_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !writable |=> last_grant_q == '0)
    else $error("pointer not cleared after a blocked output");

  a_single_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hi_grant) && $onehot0(lo_grant))
    else $error("more than one input granted");
`endif

endmodule

### dv/tb_switch_output_round_robin_arbiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_switch_output_round_robin_arbiter_unit: stream-level check of the arbiter
// Sends request items on s_axis, predicts each round-robin grant in the
// testbench and compares it with the grant item on m_axis. The output capacity
// register is stepped through several values, extremes included, between phases.
// ----------------------------------------------------------------------------
module tb_switch_output_round_robin_arbiter_unit;
  import swrr_pkg::*;

  localparam int unsigned ARB_INPUTS    = 4;
  localparam int unsigned ARB_SIZE_BITS = 16;
  localparam logic [SLOT_BITS-1:0] SIZE_MASK = SLOT_BITS'((1 << ARB_SIZE_BITS) - 1);
  localparam int unsigned RAND_BLOCKS   = 6;
  localparam int unsigned BLOCK_ITEMS   = 250;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned NUM_DIR       = 24;

  typedef struct packed {
    logic [ARB_INPUTS-1:0]           present;
    logic [ARB_INPUTS-1:0]           ready;
    logic [ARB_INPUTS-1:0]           readable;
    logic [ARB_INPUTS-1:0]           routes;
    logic [ARB_INPUTS*SLOT_BITS-1:0] sizes;
    logic [FILL_BITS-1:0]            fill;
    logic                            writable;
  } req_t;

  typedef struct packed {
    logic                  cap_wr;
    logic [CAP_BITS-1:0]   cap;
    logic [3:0]            present;
    logic [3:0]            ready;
    logic [3:0]            readable;
    logic [3:0]            routes;
    logic [63:0]           sizes;
    logic [FILL_BITS-1:0]  fill;
    logic                  writable;
    logic                  typed;
    logic                  exp_valid;
    logic [IDX_BITS-1:0]   exp_index;
  } dir_row_t;

  // Columns: cap write, cap, present, ready, readable, routes, sizes, fill,
  // writable, typed, expected valid, expected index.
  localparam dir_row_t DIR_TAB [NUM_DIR] = '{
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b1, 1'b1, 2'd1},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b0, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'h0, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'h0, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'h0, 4'hF, 64'h0, 16'd0,    1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'h0, 64'h0, 16'd0,    1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'h1, 4'h1, 4'h1, 4'h1, 64'h0, 16'd0,    1'b1, 1'b1, 1'b1, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
      1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'hFFFF_FFFF_0018_FFFF, 16'd1000,
      1'b1, 1'b1, 1'b1, 2'd1},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'hFFFF_0019_FFFF_FFFF, 16'd1000,
      1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hA, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hA, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b1, 16'hFFFF,  4'hF, 4'hF, 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
      1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0,
      1'b1, 1'b1, 1'b1, 2'd1},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'hFFFF_0000_FFFF_FFFF, 16'hFFFF,
      1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b1, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd0,    1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0001_0001_0001_0001, 16'd0,
      1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0, 16'd1,    1'b1, 1'b1, 1'b0, 2'd0},
    '{1'b1, 16'd1,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0001_0001_0001_0001, 16'd0,
      1'b1, 1'b1, 1'b1, 2'd1},
    '{1'b0, 16'd0,     4'hF, 4'hF, 4'hF, 4'hF, 64'h0001_0000_0001_0001, 16'd1,
      1'b1, 1'b0, 1'b0, 2'd0},
    '{1'b0, 16'd0,     4'h5, 4'hA, 4'hF, 4'hF, 64'hA5A5_5A5A_A5A5_5A5A, 16'h5A5A,
      1'b1, 1'b1, 1'b0, 2'd0}
  };

  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [CAP_BITS-1:0]      cfg_data_i    = '0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;

  logic [CAP_BITS-1:0] cap_shadow = CAP_RESET;
  logic [IDX_BITS-1:0] ptr_shadow = '0;
  res_t                expected_grants [$];
  int unsigned         mismatch_count = 0;
  int unsigned         snd_idle_pct   = 0;
  int unsigned         rcv_idle_pct   = 0;
  res_t                mon_got;
  res_t                mon_want;

  switch_output_round_robin_arbiter_unit #(
    .NUM_INPUTS(ARB_INPUTS),
    .SIZE_BITS (ARB_SIZE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data_i   (cfg_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_switch_output_round_robin_arbiter_unit NOT OK");
    $finish;
  end

  // Scans the inputs after the pointer and grants the first eligible one whose
  // message fits; the pointer falls back to zero when nothing is granted.
  function automatic res_t predict_grant(input req_t r);
    logic [ARB_INPUTS-1:0] elig;
    logic [SUM_BITS-1:0]   need;
    logic [SLOT_BITS-1:0]  size;
    int unsigned           k;
    int unsigned           idx;
    res_t                  g;
    elig = r.present & r.ready & r.readable & r.routes;
    g = '0;
    if (r.writable) begin
      for (k = 1; k <= ARB_INPUTS; k++) begin
        idx  = (int'(ptr_shadow) + k) % ARB_INPUTS;
        size = r.sizes[SLOT_BITS*idx +: SLOT_BITS] & SIZE_MASK;
        need = SUM_BITS'(r.fill) + SUM_BITS'(size);
        if (!g.grant_valid && elig[idx] && need <= SUM_BITS'(cap_shadow)) begin
          g.grant_valid = 1'b1;
          g.grant_index = IDX_BITS'(idx);
        end
      end
    end
    ptr_shadow = g.grant_index;
    return g;
  endfunction

  // Mostly eligible inputs with sizes placed around the room left in the
  // output buffer; a quarter of the items are raw noise.
  function automatic req_t random_request();
    req_t                r;
    logic [127:0]        noise;
    logic [SLOT_BITS-1:0] room;
    int unsigned         s;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    if ($urandom_range(99) < 25) return r;
    r.present  = ~ARB_INPUTS'($urandom & $urandom & $urandom);
    r.ready    = ~ARB_INPUTS'($urandom & $urandom & $urandom);
    r.readable = ~ARB_INPUTS'($urandom & $urandom & $urandom);
    r.routes   = ~ARB_INPUTS'($urandom & $urandom & $urandom);
    case ($urandom_range(3))
      0: r.fill = '0;
      1: r.fill = FILL_BITS'($urandom_range(cap_shadow));
      2: r.fill = '1;
      default: ;
    endcase
    room = (cap_shadow > r.fill) ? SLOT_BITS'(cap_shadow - r.fill) : '0;
    for (s = 0; s < ARB_INPUTS; s++) begin
      case ($urandom_range(5))
        0: r.sizes[SLOT_BITS*s +: SLOT_BITS] = '0;
        1: r.sizes[SLOT_BITS*s +: SLOT_BITS] = room;
        2: r.sizes[SLOT_BITS*s +: SLOT_BITS] = room + 16'd1;
        3: r.sizes[SLOT_BITS*s +: SLOT_BITS] = SLOT_BITS'($urandom_range(room));
        4: r.sizes[SLOT_BITS*s +: SLOT_BITS] = '1;
        default: ;
      endcase
    end
    r.writable = ($urandom_range(9) != 0);
    return r;
  endfunction

  task automatic send_item(input req_t r, input logic typed, input res_t typed_res);
    res_t g;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, r.writable, r.fill, r.sizes,
                      r.routes, r.readable, r.ready, r.present};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    g = predict_grant(r);
    expected_grants.push_back(typed ? typed_res : g);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_grants.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_shadow = value;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      if (expected_grants.size() == 0) begin
        $display("%0t: grant item with none expected, valid %0d index %0d",
                 $time, mon_got.grant_valid, mon_got.grant_index);
        mismatch_count++;
      end else begin
        mon_want = expected_grants.pop_front();
        if (mon_got.grant_valid !== mon_want.grant_valid) begin
          $display("%0t: grant_valid mismatch, expected %0d, actual %0d",
                   $time, mon_want.grant_valid, mon_got.grant_valid);
          mismatch_count++;
        end
        if (mon_got.grant_index !== mon_want.grant_index) begin
          $display("%0t: grant_index mismatch, expected %0d, actual %0d",
                   $time, mon_want.grant_index, mon_got.grant_index);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t    row;
    req_t        r;
    res_t        tr;
    int unsigned b;
    int unsigned n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 29;
    rcv_idle_pct = 57;
    for (n = 0; n < NUM_DIR; n++) begin
      row = DIR_TAB[n];
      if (row.cap_wr) begin
        wait_drained();
        write_capacity(row.cap);
      end
      r.present        = row.present;
      r.ready          = row.ready;
      r.readable       = row.readable;
      r.routes         = row.routes;
      r.sizes          = row.sizes;
      r.fill           = row.fill;
      r.writable       = row.writable;
      tr.grant_valid   = row.exp_valid;
      tr.grant_index   = row.exp_index;
      send_item(r, row.typed, tr);
    end

    for (b = 0; b < RAND_BLOCKS; b++) begin
      wait_drained();
      case (b)
        0: write_capacity(CAP_RESET);
        1: write_capacity(16'hFFFF);
        2: write_capacity(16'd1);
        3: write_capacity(CAP_BITS'($urandom_range(1, 65535)));
        default: write_capacity(CAP_BITS'($urandom_range(1, 300)));
      endcase
      snd_idle_pct = (b < 2) ? 29 : (b < 4) ? 57 : 0;
      rcv_idle_pct = (b < 2) ? 57 : (b < 4) ? 29 : 0;
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        // Once in the run, hold the sender until every grant has come back.
        if (b == 1 && n == BLOCK_ITEMS / 2) wait_drained();
        send_item(random_request(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_switch_output_round_robin_arbiter_unit OK");
    end else begin
      $display("tb_switch_output_round_robin_arbiter_unit NOT OK");
    end
    $finish;
  end

endmodule
